// File: rtl/core/dtp_pkg.sv
// Shared constants and types for the delta trace decoder and plotter.
`default_nettype none

package dtp_pkg;

  // Screen and row counter defaults
  localparam int DTP_SCREEN_WIDTH  = 1024;
  localparam int DTP_SCREEN_HEIGHT = 768;
  localparam int DTP_ROW_BITS      = 24;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int PIX_W   = 10;
  localparam int COLOR_W = 6;
  localparam int COL_W   = 32;
  localparam int MAG_W   = 32;
  localparam int CFG_W   = 49;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET = 2'd3;

  // Configuration reset values, signed Q16.32
  localparam logic signed [CFG_W-1:0] X_SCALE_RST  = 49'sd0;
  localparam logic signed [CFG_W-1:0] X_OFFSET_RST = 49'sd8589934592;
  localparam logic signed [CFG_W-1:0] Y_SCALE_RST  = 49'sd0;
  localparam logic signed [CFG_W-1:0] Y_OFFSET_RST = 49'sd3281355620352;

  // Color codes
  localparam logic [COLOR_W-1:0] COLOR_FRAME   = 6'd15;
  localparam logic [COLOR_W-1:0] COLOR_ZERO    = 6'd30;
  localparam logic [COLOR_W-1:0] COLOR_SIXTEEN = 6'd31;

  // Load strobes of the map pipeline stages
  typedef struct packed {
    logic ld2;
    logic ld3;
    logic ld4;
  } dtp_pipe_en_t;

  // Plot request from the decoder
  typedef struct packed {
    logic               plot;
    logic [COL_W-1:0]   col;
    logic [COLOR_W-1:0] color;
  } dtp_plot_t;

endpackage

`default_nettype wire

// File: rtl/core/dtp_if.sv
// Valid/ready channel interfaces for trace bytes and plotted pixels.
`default_nettype none

interface dtp_in_if import dtp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] stream_byte;
  logic              frame_start;

  modport source (output valid, output stream_byte, output frame_start, input ready);
  modport sink   (input valid, input stream_byte, input frame_start, output ready);
endinterface

interface dtp_out_if import dtp_pkg::*;;
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   pixel_x;
  logic [PIX_W-1:0]   pixel_y;
  logic [COLOR_W-1:0] pixel_color;

  modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
                  input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input pixel_color,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/dtp_decode.sv
// Byte decoder: code phase, running column, row count and draw color.
`default_nettype none

module dtp_decode import dtp_pkg::*; #(
  parameter int ROW_BITS = DTP_ROW_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                acc,
  input  wire logic [BYTE_W-1:0]   stream_byte,
  input  wire logic                frame_start,
  output dtp_plot_t                req,
  output logic      [ROW_BITS-1:0] req_row
);

  localparam logic [1:0] PH_LEAD   = 2'd0;
  localparam logic [1:0] PH_TWO_B1 = 2'd1;
  localparam logic [1:0] PH_TRI_B1 = 2'd2;
  localparam logic [1:0] PH_TRI_B2 = 2'd3;

  logic [1:0]          phase_r, phase_nxt, phase_e;
  logic [BYTE_W-1:0]   lead_r, lead_nxt;
  logic [BYTE_W-1:0]   second_r, second_nxt;
  logic [COL_W-1:0]    col_r, col_nxt, col_e;
  logic [ROW_BITS-1:0] row_r, row_nxt, row_e;
  logic [COLOR_W-1:0]  color_r, color_nxt, color_e;
  logic [21:0]         w;
  logic                plot;

  // Decode one byte against the current phase
  always_comb begin
    phase_e    = frame_start ? PH_LEAD : phase_r;
    col_e      = frame_start ? '0 : col_r;
    row_e      = frame_start ? '0 : row_r;
    color_e    = frame_start ? COLOR_FRAME : color_r;
    phase_nxt  = phase_e;
    lead_nxt   = lead_r;
    second_nxt = second_r;
    col_nxt    = col_e;
    row_nxt    = row_e;
    color_nxt  = color_e;
    plot       = 1'b0;
    w          = {stream_byte, second_r, lead_r[5:0]};
    case (phase_e)
      PH_LEAD: begin
        lead_nxt = stream_byte;
        if (!stream_byte[7]) begin
          col_nxt = col_e + COL_W'(stream_byte);
          plot    = 1'b1;
        end else begin
          phase_nxt = stream_byte[6] ? PH_TRI_B1 : PH_TWO_B1;
        end
      end
      PH_TWO_B1: begin
        phase_nxt = PH_LEAD;
        if (stream_byte == '0) begin
          if (lead_r == 8'h80) begin
            row_nxt = row_e + ROW_BITS'(1);
            col_nxt = '0;
          end else begin
            col_nxt = col_e + COL_W'({lead_r[5:0], 22'd0});
          end
        end else begin
          col_nxt = col_e + COL_W'({stream_byte, lead_r[5:0]});
          plot    = 1'b1;
        end
      end
      PH_TRI_B1: begin
        second_nxt = stream_byte;
        phase_nxt  = PH_TRI_B2;
      end
      default: begin
        phase_nxt = PH_LEAD;
        if (w[21:6] == '0) begin
          if (w[5:0] == 6'd0)       color_nxt = COLOR_ZERO;
          else if (w[5:0] == 6'd16) color_nxt = COLOR_SIXTEEN;
          else                      color_nxt = w[5:0];
        end else begin
          col_nxt = col_e + COL_W'(w);
          plot    = 1'b1;
        end
      end
    endcase
  end

  // Hand the updated position to the map pipeline
  assign req.plot  = plot;
  assign req.col   = col_nxt;
  assign req.color = color_e;
  assign req_row   = row_e;

  // Advance decoder state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEAD;
      lead_r   <= '0;
      second_r <= '0;
      col_r    <= '0;
      row_r    <= '0;
      color_r  <= COLOR_FRAME;
    end else if (acc) begin
      phase_r  <= phase_nxt;
      lead_r   <= lead_nxt;
      second_r <= second_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      color_r  <= color_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dtp_axis.sv
// One screen axis: Q16.32 scale times magnitude plus offset, truncate and clip.
`default_nettype none

module dtp_axis import dtp_pkg::*; #(
  parameter int LIMIT = DTP_SCREEN_WIDTH
) (
  input  wire logic                    clk,
  input  wire dtp_pipe_en_t            en,
  input  wire logic signed [CFG_W-1:0] scale,
  input  wire logic signed [CFG_W-1:0] offset,
  input  wire logic        [MAG_W-1:0] mag,
  input  wire logic                    mag_neg,
  output logic                         vis,
  output logic             [PIX_W-1:0] coord_r
);

  logic [CFG_W-1:0] am;
  logic [16:0]      ahi;
  logic [31:0]      alo;
  logic [48:0]      t_r;
  logic [63:0]      u_r;
  logic             sneg_r, sneg3_r;
  logic             big_t;
  logic [64:0]      m;
  logic [63:0]      sm, sm_r;
  logic             big_r;
  logic [63:0]      r;
  logic             fits;

  // Split the scale magnitude into high and low partial products
  assign am  = scale[CFG_W-1] ? CFG_W'(-scale) : scale;
  assign ahi = am[48:32];
  assign alo = am[31:0];

  always_ff @(posedge clk) begin
    if (en.ld2) begin
      t_r    <= 49'(ahi) * 49'(mag);
      u_r    <= 64'(alo) * 64'(mag);
      sneg_r <= scale[CFG_W-1] ^ mag_neg;
    end
  end

  // Combine partial products, flag overflow, apply sign
  assign big_t = |t_r[48:30];
  assign m     = 65'({t_r[29:0], 32'd0}) + 65'(u_r);
  assign sm    = sneg_r ? 64'(-m[63:0]) : m[63:0];

  always_ff @(posedge clk) begin
    if (en.ld3) begin
      sm_r    <= sm;
      big_r   <= big_t | (|m[64:62]);
      sneg3_r <= sneg_r;
    end
  end

  // Add offset and clip against the screen edge
  assign r = sm_r + 64'(offset);
  always_comb begin
    if (r[63]) fits = (r[63:32] == '1) && (r[31:0] != '0);
    else       fits = (r[63:32] < 32'(LIMIT));
  end
  assign vis = !big_r && fits && (sneg3_r || !r[63] || fits);

  always_ff @(posedge clk) begin
    if (en.ld4) begin
      coord_r <= r[63] ? '0 : r[32 +: PIX_W];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/delta_trace_decode_plot.sv
// Top level of the delta trace decoder and plotter.
// Takes one trace byte per cycle while the input is ready and returns at most one
// pixel per byte. A byte that completes a delta code passes through the first
// stage register and the map pipeline (partial-product multipliers, sign and
// overflow stage, offset add and clip) to the output register. Each stage has
// its own valid bit, so input keeps flowing while a finished pixel waits to be
// taken, until the three stages behind it are full. Configuration writes must
// be made while no item is in flight.
`default_nettype none

module delta_trace_decode_plot import dtp_pkg::*; #(
  parameter int SCREEN_WIDTH  = DTP_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DTP_SCREEN_HEIGHT,
  parameter int ROW_BITS      = DTP_ROW_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  dtp_in_if.sink                    in_ch,
  dtp_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  logic signed [CFG_W-1:0] x_scale_r, x_offset_r, y_scale_r, y_offset_r;

  logic                acc;
  dtp_plot_t           req;
  logic [ROW_BITS-1:0] req_row;

  logic                v1_r, v2_r, v3_r, out_valid_r;
  logic                rdy1, rdy2, rdy3, rdy4;
  dtp_pipe_en_t        en;
  logic [ROW_BITS-1:0] row1_r;
  logic [COL_W-1:0]    col1_r;
  logic [COLOR_W-1:0]  color1_r, color2_r, color3_r, color_out_r;
  logic [MAG_W-1:0]    cmag;
  logic                vis_x, vis_y;
  logic [PIX_W-1:0]    px_r, py_r;

  // Hold the map registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_scale_r  <= X_SCALE_RST;
      x_offset_r <= X_OFFSET_RST;
      y_scale_r  <= Y_SCALE_RST;
      y_offset_r <= Y_OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_X_SCALE:  x_scale_r  <= cfg_wdata;
        CFG_X_OFFSET: x_offset_r <= cfg_wdata;
        CFG_Y_SCALE:  y_scale_r  <= cfg_wdata;
        CFG_Y_OFFSET: y_offset_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage readiness, back from the output register
  assign rdy4   = !out_valid_r || out_ch.ready;
  assign rdy3   = !v3_r || rdy4;
  assign rdy2   = !v2_r || rdy3;
  assign rdy1   = !v1_r || rdy2;
  assign en.ld2 = v1_r && rdy2;
  assign en.ld3 = v2_r && rdy3;
  assign en.ld4 = v3_r && rdy4;

  assign in_ch.ready = rdy1;
  assign acc         = in_ch.valid && rdy1;

  dtp_decode #(
    .ROW_BITS(ROW_BITS)
  ) u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .stream_byte(in_ch.stream_byte),
    .frame_start(in_ch.frame_start),
    .req        (req),
    .req_row    (req_row)
  );

  // Advance stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= acc && req.plot;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) out_valid_r <= v3_r && vis_x && vis_y;
    end
  end

  // Carry position and color along the pipeline
  always_ff @(posedge clk) begin
    if (acc && req.plot && rdy1) begin
      row1_r   <= req_row;
      col1_r   <= req.col;
      color1_r <= req.color;
    end
    if (en.ld2) color2_r <= color1_r;
    if (en.ld3) color3_r <= color2_r;
    if (en.ld4) color_out_r <= color3_r;
  end

  // Column is read as signed: magnitude and sign
  assign cmag = col1_r[COL_W-1] ? MAG_W'(-col1_r) : MAG_W'(col1_r);

  dtp_axis #(
    .LIMIT(SCREEN_WIDTH)
  ) u_axis_x (
    .clk    (clk),
    .en     (en),
    .scale  (x_scale_r),
    .offset (x_offset_r),
    .mag    (MAG_W'(row1_r)),
    .mag_neg(1'b0),
    .vis    (vis_x),
    .coord_r(px_r)
  );

  dtp_axis #(
    .LIMIT(SCREEN_HEIGHT)
  ) u_axis_y (
    .clk    (clk),
    .en     (en),
    .scale  (y_scale_r),
    .offset (y_offset_r),
    .mag    (cmag),
    .mag_neg(col1_r[COL_W-1]),
    .vis    (vis_y),
    .coord_r(py_r)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_x     = px_r;
  assign out_ch.pixel_y     = py_r;
  assign out_ch.pixel_color = color_out_r;

  // A new pixel only appears from a filled third stage
  a_out_from_s3: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v3_r))
    else $error("pixel appeared without a stage-three item");

  // Input stalls only while the first stage is occupied
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> v1_r)
    else $error("input stalled with an empty first stage");

  // Every plotting item enters the first stage
  a_plot_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && req.plot) |=> v1_r)
    else $error("plot request dropped at the first stage");

  // A held pixel is not replaced while the sink stalls
  a_hold_color: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(color_out_r)))
    else $error("stalled pixel lost or changed");

endmodule

`default_nettype wire
